// ===== design/tridiagonal_solver_assert.svh =====
// Assertion macros shared by the tridiagonal solver RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef TRIDIAGONAL_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tds_pkg.sv =====
// Package for the tridiagonal solver: widths, defaults, register codes,
// controller command struct and the saturation helper. No dependencies.
`default_nettype none

package tds_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 24;
    localparam int SAMPLE_WIDTH    = 32;
    localparam int INDEX_WIDTH     = 6;
    localparam int DIAG_WIDTH      = 8;
    localparam int SIZE_WIDTH      = 7;
    localparam int H_WIDTH         = 32;
    localparam int DIV_IN_WIDTH    = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYSTEM_SIZE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUB_DIAG    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAIN_DIAG   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUPER_DIAG  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_H_SQUARED   = 3'd4;

    localparam logic [SIZE_WIDTH-1:0]        SIZE_RESET  = 7'd64;
    localparam logic signed [DIAG_WIDTH-1:0] SUB_RESET   = -8'sd1;
    localparam logic signed [DIAG_WIDTH-1:0] MAIN_RESET  = 8'sd2;
    localparam logic signed [DIAG_WIDTH-1:0] SUPER_RESET = -8'sd1;
    localparam logic [H_WIDTH-1:0]           H_RESET     = 32'd1048576;

    typedef struct packed {
        logic cap;         // capture input sample
        logic scale;       // sample times h squared
        logic wr_rhs;      // store scaled sample
        logic init;        // first row of elimination
        logic fdiv_start;  // start multiplier division
        logic m_take;      // latch multiplier
        logic fmul;        // m times previous reduced rhs
        logic fupd;        // write pivot and reduced rhs
        logic bnum;        // form back substitution numerator
        logic bdiv_start;  // start solution division
        logic sol_wr;      // write solution value
    } tds_cmd_t;

    // Clamp to a signed range of w bits.
    function automatic logic signed [63:0] sat_to(input logic signed [63:0] x,
                                                  input int unsigned w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            return hi;
        else if (x < lo)
            return lo;
        else
            return x;
    endfunction

endpackage

`default_nettype wire

// ===== design/tds_stream_if.sv =====
// Valid/ready stream interfaces for the solver's input and result channels.
// Depends on tds_pkg for field widths.
`default_nettype none

interface tds_rhs_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [tds_pkg::SAMPLE_WIDTH-1:0]    rhs_sample;
    modport source (output valid, output rhs_sample, input ready);
    modport sink   (input valid, input rhs_sample, output ready);
endinterface

interface tds_sol_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [tds_pkg::SAMPLE_WIDTH-1:0]    solution_value;
    logic [tds_pkg::INDEX_WIDTH-1:0]            point_index;
    logic                                       last_of_run;
    logic                                       pivot_fault;
    modport source (output valid, output solution_value, output point_index,
                    output last_of_run, output pivot_fault, input ready);
    modport sink   (input valid, input solution_value, input point_index,
                    input last_of_run, input pivot_fault, output ready);
endinterface

`default_nettype wire

// ===== design/tridiagonal_solver.sv =====
// Tridiagonal solver with constant diagonals (Thomas elimination), Q8.24.
// Input channel rhs: one right-hand sample per transfer. Output channel
// sol: one solution value per transfer, in index order, last one marked.
// Configuration: cfg_wr_en / cfg_index / cfg_data, write only, taken at
// any edge with cfg_wr_en high; writing system_size drops a partial load.
// Each sample is captured, scaled and stored in turn (states LOAD, SCALE,
// STORE). The sample that completes the load starts the solve: each forward
// element after the first and each back element waits on the 56-step
// bit-serial divider. Results then leave one at a time, each read from RAM
// and then transferred. No sample is taken during the solve or
// while results drain. A stalled receiver simply holds the current result;
// the block waits until it is taken. Reset returns the sequencer to loading
// with an empty load, restores register defaults (64, -1, 2, -1, 2^-12) and
// clears the fault flag; the value stores are not cleared and need no pass.
// Depends on tds_pkg, tds_stream_if, tds_ctrl and tds_datapath.
`default_nettype none

module tridiagonal_solver #(
    parameter int MAX_POINTS  = tds_pkg::MAX_POINTS_DEF,
    parameter int VALUE_WIDTH = tds_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [tds_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [tds_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    tds_rhs_if.sink                                    rhs,
    tds_sol_if.source                                  sol
);
    import tds_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    logic [SIZE_WIDTH-1:0]        size_reg;
    logic signed [DIAG_WIDTH-1:0] sub_reg;
    logic signed [DIAG_WIDTH-1:0] main_reg;
    logic signed [DIAG_WIDTH-1:0] super_reg;
    logic [H_WIDTH-1:0]           h_reg;
    logic                         size_wr;

    tds_cmd_t      cmd;
    logic [AW-1:0] idx;
    logic [AW-1:0] load_idx;
    logic          div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            sub_reg   <= SUB_RESET;
            main_reg  <= MAIN_RESET;
            super_reg <= SUPER_RESET;
            h_reg     <= H_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SYSTEM_SIZE: size_reg  <= cfg_data[SIZE_WIDTH-1:0];
                REG_SUB_DIAG:    sub_reg   <= cfg_data[DIAG_WIDTH-1:0];
                REG_MAIN_DIAG:   main_reg  <= cfg_data[DIAG_WIDTH-1:0];
                REG_SUPER_DIAG:  super_reg <= cfg_data[DIAG_WIDTH-1:0];
                REG_H_SQUARED:   h_reg     <= cfg_data[H_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign size_wr = cfg_wr_en && (cfg_index == REG_SYSTEM_SIZE);

    tds_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(rhs.valid), .in_ready(rhs.ready),
        .out_valid(sol.valid), .out_ready(sol.ready), .out_last(sol.last_of_run),
        .system_size(size_reg), .size_wr(size_wr), .div_done(div_done),
        .cmd(cmd), .idx(idx), .load_idx(load_idx)
    );

    tds_datapath #(.MAX_POINTS(MAX_POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .idx(idx), .load_idx(load_idx),
        .sub_diag(sub_reg), .main_diag(main_reg), .super_diag(super_reg),
        .h_squared(h_reg), .rhs_sample(rhs.rhs_sample), .div_done(div_done),
        .solution_value(sol.solution_value), .pivot_fault(sol.pivot_fault)
    );

    assign sol.point_index = INDEX_WIDTH'(idx);

endmodule

`default_nettype wire

// ===== design/tds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/tds_div.sv =====
// Restoring divider, one quotient bit per cycle: (num * 2^24) / den,
// truncated toward zero and saturated. Depends on tds_pkg.
`default_nettype none

module tds_div #(
    parameter int SAT_WIDTH = tds_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [tds_pkg::DIV_IN_WIDTH-1:0] num,
    input  wire logic signed [tds_pkg::DIV_IN_WIDTH-1:0] den,
    output logic                                        done,
    output logic signed [SAT_WIDTH-1:0]                 quot,
    output logic                                        zero_div
);
    import tds_pkg::*;

    localparam int DIVD_W = DIV_IN_WIDTH + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    logic                      busy_reg;
    logic                      fin_reg;
    logic                      done_reg;
    logic                      dz_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [DIVD_W-1:0]         q_reg;
    logic [DIV_IN_WIDTH:0]     rem_reg;
    logic [DIV_IN_WIDTH-1:0]   den_reg;
    logic                      neg_reg;
    logic signed [SAT_WIDTH-1:0] quot_reg;

    logic [DIV_IN_WIDTH-1:0]   num_mag;
    logic [DIV_IN_WIDTH-1:0]   den_mag;
    logic [DIV_IN_WIDTH:0]     shifted;
    logic [DIV_IN_WIDTH:0]     trial;
    logic                      fits;
    logic signed [63:0]        signed_q;

    always_comb
    begin
        num_mag  = num[DIV_IN_WIDTH-1] ? (~num + 1'b1) : num;
        den_mag  = den[DIV_IN_WIDTH-1] ? (~den + 1'b1) : den;
        shifted  = {rem_reg[DIV_IN_WIDTH-1:0], q_reg[DIVD_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        trial    = shifted - {1'b0, den_reg};
        signed_q = neg_reg ? -$signed(64'(q_reg)) : $signed(64'(q_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dz_reg <= (den == '0);
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(DIVD_W);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= num[DIV_IN_WIDTH-1] ^ den[DIV_IN_WIDTH-1];
            if (den == '0)
            begin
                quot_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial : shifted;
            q_reg   <= {q_reg[DIVD_W-2:0], fits};
        end
        else if (fin_reg)
        begin
            quot_reg <= SAT_WIDTH'(sat_to(signed_q, SAT_WIDTH));
        end
    end

    assign done     = done_reg;
    assign quot     = quot_reg;
    assign zero_div = dz_reg;

endmodule

`default_nettype wire

// ===== design/tds_datapath.sv =====
// Solver datapath: sample scaling, elimination and back substitution
// arithmetic, the four value stores and the divider. Depends on tds_pkg,
// tds_ram and tds_div.
`default_nettype none

module tds_datapath #(
    parameter int MAX_POINTS  = tds_pkg::MAX_POINTS_DEF,
    parameter int VALUE_WIDTH = tds_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire tds_pkg::tds_cmd_t                        cmd,
    input  wire logic [$clog2(MAX_POINTS)-1:0]            idx,
    input  wire logic [$clog2(MAX_POINTS)-1:0]            load_idx,
    input  wire logic signed [tds_pkg::DIAG_WIDTH-1:0]    sub_diag,
    input  wire logic signed [tds_pkg::DIAG_WIDTH-1:0]    main_diag,
    input  wire logic signed [tds_pkg::DIAG_WIDTH-1:0]    super_diag,
    input  wire logic [tds_pkg::H_WIDTH-1:0]              h_squared,
    input  wire logic signed [tds_pkg::SAMPLE_WIDTH-1:0]  rhs_sample,
    output logic                                          div_done,
    output logic signed [tds_pkg::SAMPLE_WIDTH-1:0]       solution_value,
    output logic                                          pivot_fault
);
    import tds_pkg::*;

    localparam int VWC = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    logic signed [SAMPLE_WIDTH-1:0] f_reg;
    logic signed [63:0]             prod_reg;
    logic signed [63:0]             prod_next;
    logic signed [VWC-1:0]          piv_prev_reg;
    logic signed [VWC-1:0]          red_prev_reg;
    logic signed [VWC-1:0]          v_next_reg;
    logic signed [VWC-1:0]          m_reg;
    logic signed [VWC-1:0]          num_reg;
    logic                           fault_reg;

    logic [VWC-1:0] rhs_rd_raw, piv_rd_raw, red_rd_raw, sol_rd_raw;
    logic signed [VWC-1:0] rhs_rd, piv_rd, red_rd, sol_rd;

    logic signed [VWC-1:0] g_val;
    logic signed [VWC-1:0] piv0;
    logic signed [VWC-1:0] piv_upd;
    logic signed [VWC-1:0] red_upd;
    logic signed [VWC-1:0] piv_w;
    logic signed [VWC-1:0] red_w;
    logic signed [VWC-1:0] num_v;
    logic signed [63:0]    round_g;
    logic signed [63:0]    round_r;
    logic signed [63:0]    bq;

    logic                            div_start;
    logic signed [DIV_IN_WIDTH-1:0]  div_num;
    logic signed [DIV_IN_WIDTH-1:0]  div_den;
    logic signed [VWC-1:0]           div_q;
    logic                            div_dz;

    assign rhs_rd = $signed(rhs_rd_raw);
    assign piv_rd = $signed(piv_rd_raw);
    assign red_rd = $signed(red_rd_raw);
    assign sol_rd = $signed(sol_rd_raw);

    always_comb
    begin
        if (cmd.scale)
            prod_next = 64'(f_reg) * $signed(64'(h_squared));
        else
            prod_next = 64'(m_reg) * 64'(red_prev_reg);

        round_g = prod_reg + 64'sh0000_0000_8000_0000;
        round_r = prod_reg + 64'sh0000_0000_0080_0000;
        bq      = 64'(main_diag) <<< FRAC_BITS;

        g_val   = VWC'(sat_to(round_g >>> 32, VWC));
        piv0    = VWC'(sat_to(bq, VWC));
        piv_upd = VWC'(sat_to(bq - 64'(m_reg) * 64'(super_diag), VWC));
        red_upd = VWC'(sat_to(64'(rhs_rd) - (round_r >>> FRAC_BITS), VWC));
        num_v   = VWC'(sat_to(64'(red_rd) - 64'(super_diag) * 64'(v_next_reg), VWC));

        piv_w = cmd.init ? piv0 : piv_upd;
        red_w = cmd.init ? rhs_rd : red_upd;

        div_start = cmd.fdiv_start | cmd.bdiv_start;
        if (cmd.fdiv_start)
        begin
            div_num = DIV_IN_WIDTH'(sub_diag) <<< FRAC_BITS;
            div_den = DIV_IN_WIDTH'(piv_prev_reg);
        end
        else
        begin
            div_num = DIV_IN_WIDTH'(num_reg);
            div_den = DIV_IN_WIDTH'(piv_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
            f_reg <= rhs_sample;
        if (cmd.scale || cmd.fmul)
            prod_reg <= prod_next;
        if (cmd.m_take)
            m_reg <= div_q;
        if (cmd.bnum)
            num_reg <= num_v;
        if (cmd.init || cmd.fupd)
        begin
            piv_prev_reg <= piv_w;
            red_prev_reg <= red_w;
        end
        if (cmd.init)
            v_next_reg <= '0;
        else if (cmd.sol_wr)
            v_next_reg <= div_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fault_reg <= 1'b0;
        else if (cmd.init)
            fault_reg <= 1'b0;
        else if (div_done && div_dz)
            fault_reg <= 1'b1;
    end

    tds_ram #(.WIDTH(VWC), .DEPTH(MAX_POINTS)) u_rhs_ram (
        .clk(clk), .we(cmd.wr_rhs), .waddr(load_idx), .wdata(g_val),
        .raddr(idx), .rdata(rhs_rd_raw)
    );

    tds_ram #(.WIDTH(VWC), .DEPTH(MAX_POINTS)) u_piv_ram (
        .clk(clk), .we(cmd.init | cmd.fupd), .waddr(idx), .wdata(piv_w),
        .raddr(idx), .rdata(piv_rd_raw)
    );

    tds_ram #(.WIDTH(VWC), .DEPTH(MAX_POINTS)) u_red_ram (
        .clk(clk), .we(cmd.init | cmd.fupd), .waddr(idx), .wdata(red_w),
        .raddr(idx), .rdata(red_rd_raw)
    );

    tds_ram #(.WIDTH(VWC), .DEPTH(MAX_POINTS)) u_sol_ram (
        .clk(clk), .we(cmd.sol_wr), .waddr(idx), .wdata(div_q),
        .raddr(idx), .rdata(sol_rd_raw)
    );

    tds_div #(.SAT_WIDTH(VWC)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quot(div_q), .zero_div(div_dz)
    );

    assign solution_value = SAMPLE_WIDTH'(sol_rd);
    assign pivot_fault    = fault_reg;

endmodule

`default_nettype wire

// ===== design/tds_ctrl.sv =====
// Solver sequencer: load, forward elimination, back substitution and
// result output. Drives tds_datapath through tds_pkg::tds_cmd_t.
`default_nettype none

`include "tridiagonal_solver_assert.svh"

module tds_ctrl #(
    parameter int MAX_POINTS = tds_pkg::MAX_POINTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_last,
    input  wire logic [tds_pkg::SIZE_WIDTH-1:0]    system_size,
    input  wire logic                              size_wr,
    input  wire logic                              div_done,
    output tds_pkg::tds_cmd_t                      cmd,
    output logic [$clog2(MAX_POINTS)-1:0]          idx,
    output logic [$clog2(MAX_POINTS)-1:0]          load_idx
);
    import tds_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_STORE = 4'd2;
    localparam logic [3:0] ST_F0RD  = 4'd3;
    localparam logic [3:0] ST_F0    = 4'd4;
    localparam logic [3:0] ST_FRD   = 4'd5;
    localparam logic [3:0] ST_FDIV  = 4'd6;
    localparam logic [3:0] ST_FMUL  = 4'd7;
    localparam logic [3:0] ST_FUPD  = 4'd8;
    localparam logic [3:0] ST_BRD   = 4'd9;
    localparam logic [3:0] ST_BNUM  = 4'd10;
    localparam logic [3:0] ST_BST   = 4'd11;
    localparam logic [3:0] ST_BDIV  = 4'd12;
    localparam logic [3:0] ST_ORD   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] load_reg, load_next;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] n_last;
    logic          idx_last;
    logic          load_last;

    always_comb
    begin
        if (system_size < SIZE_WIDTH'(2))
            n_eff = CW'(2);
        else if (system_size > SIZE_WIDTH'(MAX_POINTS))
            n_eff = CW'(MAX_POINTS);
        else
            n_eff = CW'(system_size);
        n_last    = n_eff - 1'b1;
        idx_last  = (CW'(idx_reg) == n_last);
        load_last = (CW'(load_reg) == n_last);
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        idx_next   = idx_reg;
        load_next  = load_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.wr_rhs = 1'b1;
                if (load_last)
                begin
                    load_next  = '0;
                    idx_next   = '0;
                    state_next = ST_F0RD;
                end
                else
                begin
                    load_next  = load_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_F0RD:
                state_next = ST_F0;
            ST_F0:
            begin
                cmd.init   = 1'b1;
                idx_next   = AW'(1);
                state_next = ST_FRD;
            end
            ST_FRD:
            begin
                cmd.fdiv_start = 1'b1;
                state_next     = ST_FDIV;
            end
            ST_FDIV:
            begin
                if (div_done)
                begin
                    cmd.m_take = 1'b1;
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL:
            begin
                cmd.fmul   = 1'b1;
                state_next = ST_FUPD;
            end
            ST_FUPD:
            begin
                cmd.fupd = 1'b1;
                if (idx_last)
                    state_next = ST_BRD;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FRD;
                end
            end
            ST_BRD:
                state_next = ST_BNUM;
            ST_BNUM:
            begin
                cmd.bnum   = 1'b1;
                state_next = ST_BST;
            end
            ST_BST:
            begin
                cmd.bdiv_start = 1'b1;
                state_next     = ST_BDIV;
            end
            ST_BDIV:
            begin
                if (div_done)
                begin
                    cmd.sol_wr = 1'b1;
                    if (idx_reg == '0)
                        state_next = ST_ORD;
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_BRD;
                    end
                end
            end
            ST_ORD:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_last)
                        state_next = ST_LOAD;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_ORD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
        // a size write drops any partial load
        if (size_wr)
            load_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
            load_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            load_reg  <= load_next;
        end
    end

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_OUT);
    assign out_last  = idx_last;
    assign idx       = idx_reg;
    assign load_idx  = load_reg;

    `TDS_ASSERT_IMP(a_in_out_excl, in_ready, !out_valid, "input and output open together")
    `TDS_ASSERT_IMP(a_load_bound, 1'b1, CW'(load_reg) <= n_last, "load count past size")
    `TDS_ASSERT_NXT(a_last_to_load, out_valid && out_ready && out_last,
        state_reg == ST_LOAD, "no return to load after last transfer")
    `TDS_ASSERT_IMP(a_div_done_wait, div_done,
        state_reg == ST_FDIV || state_reg == ST_BDIV, "divider done while not waiting")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for tridiagonal_solver: stream stimulus, config writes,
// a built-in fixed-point Thomas predictor and an in-order result checker.
// Depends on tds_pkg, tds_stream_if and the tridiagonal_solver RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tds_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [5:0]         index;
        logic               last;
        logic               fault;
    } solution_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    tds_rhs_if rhs();
    tds_sol_if sol();

    tridiagonal_solver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rhs       (rhs),
        .sol       (sol)
    );

    // Predictor state
    logic [6:0]          size_reg;
    logic signed [63:0]  sub_q;
    logic signed [63:0]  main_q;
    logic signed [63:0]  super_q;
    logic signed [63:0]  hsq;
    int unsigned         loaded;
    logic                div_fault;
    logic signed [63:0]  scaled_rhs [64];
    logic signed [63:0]  pivots [64];
    logic signed [63:0]  reduced [64];
    logic signed [63:0]  solution [64];

    solution_t pending_solutions[$];

    int errors;
    int mismatches;
    int samples_sent;
    int solutions_seen;
    int solves_done;
    int gap_pct;
    int stall_pct;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        else if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q8.24 divide, truncating toward zero; zero divisor flags a fault.
    function automatic logic signed [63:0] fixed_div(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
        if (den == 0)
        begin
            div_fault = 1'b1;
            return 0;
        end
        return clamp32((num <<< 24) / den);
    endfunction

    function automatic void thomas_solve(input int unsigned n);
        logic signed [63:0] m;
        logic signed [63:0] num;
        solution_t r;
        pivots[0]  = clamp32(main_q <<< 24);
        reduced[0] = scaled_rhs[0];
        for (int i = 1; i < n; i++)
        begin
            m = fixed_div(sub_q <<< 24, pivots[i-1]);
            pivots[i]  = clamp32((main_q <<< 24) - m * super_q);
            reduced[i] = clamp32(scaled_rhs[i] - ((m * reduced[i-1] + 64'sd8388608) >>> 24));
        end
        solution[n-1] = fixed_div(reduced[n-1], pivots[n-1]);
        for (int i = n - 2; i >= 0; i--)
        begin
            num = clamp32(reduced[i] - super_q * solution[i+1]);
            solution[i] = fixed_div(num, pivots[i]);
        end
        for (int i = 0; i < n; i++)
        begin
            r.value = solution[i][31:0];
            r.index = 6'(i);
            r.last  = (i == n - 1);
            r.fault = div_fault;
            pending_solutions.push_back(r);
        end
    endfunction

    function automatic void model_sample(input logic signed [31:0] f);
        int unsigned n;
        logic signed [63:0] fx;
        n  = (size_reg < 2) ? 2 : (size_reg > 64) ? 64 : size_reg;
        fx = f;
        if (loaded >= n)
            loaded = 0;
        scaled_rhs[loaded] = clamp32((fx * hsq + 64'sd2147483648) >>> 32);
        loaded++;
        if (loaded < n)
            return;
        loaded = 0;
        div_fault = 1'b0;
        solves_done++;
        thomas_solve(n);
    endfunction

    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            REG_SYSTEM_SIZE: begin size_reg = data[6:0]; loaded = 0; end
            REG_SUB_DIAG:    sub_q   = $signed(data[7:0]);
            REG_MAIN_DIAG:   main_q  = $signed(data[7:0]);
            REG_SUPER_DIAG:  super_q = $signed(data[7:0]);
            REG_H_SQUARED:   hsq     = {32'd0, data};
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] f);
        while ($urandom_range(99) < gap_pct)
        begin
            rhs.valid = 1'b0;
            @(negedge clk);
        end
        rhs.valid      = 1'b1;
        rhs.rhs_sample = f;
        do
            @(posedge clk);
        while (!rhs.ready);
        model_sample(f);
        samples_sent++;
        @(negedge clk);
    endtask

    // Drop valid, then wait until every predicted solution has been taken.
    task automatic wait_idle();
        rhs.valid = 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            sol.ready = 1'b0;
            hold_left--;
        end
        else
            sol.ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n && sol.valid && sol.ready)
        begin
            solutions_seen++;
            if (pending_solutions.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result: value %h index %0d", sol.solution_value,
                             sol.point_index);
            end
            else
            begin
                want = pending_solutions.pop_front();
                if (sol.solution_value !== want.value || sol.point_index !== want.index ||
                    sol.last_of_run !== want.last || sol.pivot_fault !== want.fault)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp val %h idx %0d last %b flt %b, got %h %0d %b %b",
                                 want.value, want.index, want.last, want.fault,
                                 sol.solution_value, sol.point_index, sol.last_of_run,
                                 sol.pivot_fault);
                end
            end
        end
    end

    task automatic test_defaults_and_extremes();
        gap_pct = 0; stall_pct = 0;
        cfg_write(REG_SYSTEM_SIZE, 32'd2);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        wait_idle();
        cfg_write(REG_H_SQUARED, 32'hffff_ffff);
        cfg_write(REG_SUB_DIAG, 32'h7f);
        cfg_write(REG_SUPER_DIAG, 32'h80);
        cfg_write(REG_MAIN_DIAG, 32'h80);
        send_sample(32'h8000_0000);
        send_sample(32'h7fff_ffff);
        send_sample(32'h0000_0000);
        send_sample(32'hffff_ffff);
        wait_idle();
        cfg_write(REG_H_SQUARED, 32'd0);
        send_sample(32'h1234_5678);
        send_sample(32'h7fff_ffff);
        wait_idle();
    endtask

    task automatic test_zero_pivot();
        cfg_write(REG_H_SQUARED, 32'h8000_0000);
        cfg_write(REG_MAIN_DIAG, 32'd0);
        cfg_write(REG_SUB_DIAG, 32'd1);
        cfg_write(REG_SUPER_DIAG, 32'd1);
        cfg_write(REG_SYSTEM_SIZE, 32'd3);
        send_sample(32'h0100_0000);
        send_sample(32'hff00_0000);
        send_sample(32'h0080_0000);
        wait_idle();
    endtask

    task automatic test_size_and_index_edges();
        cfg_write(REG_MAIN_DIAG, 32'd2);
        cfg_write(REG_SUB_DIAG, 32'hff);
        cfg_write(REG_SUPER_DIAG, 32'hff);
        cfg_write(REG_SYSTEM_SIZE, 32'd0);   // acts as two
        send_sample(32'h0200_0000);
        send_sample(32'h0300_0000);
        wait_idle();
        cfg_write(REG_SYSTEM_SIZE, 32'd1);
        send_sample(32'h0100_0000);
        send_sample(32'hfe00_0000);
        wait_idle();
        // partial load thrown away by a size write
        cfg_write(REG_SYSTEM_SIZE, 32'd5);
        send_sample(32'h0500_0000);
        send_sample(32'h0600_0000);
        wait_idle();
        cfg_write(REG_SYSTEM_SIZE, 32'd2);
        cfg_write(3'd5, 32'hffff_ffff);
        cfg_write(3'd6, 32'h0);
        cfg_write(3'd7, 32'h5a5a_5a5a);
        send_sample(32'h0001_0000);
        send_sample(32'h0002_0000);
        wait_idle();
    endtask

    task automatic test_full_size();
        cfg_write(REG_SYSTEM_SIZE, 32'd127);  // clamps to 64
        for (int i = 0; i < 64; i++)
            send_sample($urandom);
        wait_idle();
    endtask

    task automatic test_random_solves();
        int n;
        int phase;
        phase = 0;
        while (samples_sent < 160)
        begin
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 60; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 60; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            n = ($urandom_range(9) == 0) ? 64 : $urandom_range(8, 2);
            cfg_write(REG_SYSTEM_SIZE, n);
            cfg_write(REG_SUB_DIAG, ($urandom_range(3) == 0) ? $urandom : $urandom_range(4) - 2);
            cfg_write(REG_MAIN_DIAG, ($urandom_range(3) == 0) ? $urandom : $urandom_range(8) - 4);
            cfg_write(REG_SUPER_DIAG, ($urandom_range(3) == 0) ? $urandom : $urandom_range(4) - 2);
            cfg_write(REG_H_SQUARED, $urandom);
            if (phase == 1)
                hold_left = 400;  // long receiver hold while inputs keep coming
            for (int k = 0; k < 2 * n; k++)
                send_sample($urandom);
            if ($urandom_range(4) == 0)
                send_sample($urandom);   // leave a broken load behind
            wait_idle();
            phase++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rhs.valid = 1'b0;
        rhs.rhs_sample = '0;
        sol.ready = 1'b0;
        gap_pct = 0; stall_pct = 0; hold_left = 0;
        errors = 0; mismatches = 0; samples_sent = 0; solutions_seen = 0; solves_done = 0;
        size_reg = SIZE_RESET;
        sub_q = SUB_RESET; main_q = MAIN_RESET; super_q = SUPER_RESET;
        hsq = {32'd0, H_RESET};
        loaded = 0;
        div_fault = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_defaults_and_extremes();
        test_zero_pivot();
        test_size_and_index_edges();
        test_full_size();
        test_random_solves();
        wait_idle();
        repeat (200) @(posedge clk);
        $display("covered %0d samples, %0d solves, %0d solutions checked, %0d mismatches",
                 samples_sent, solves_done, solutions_seen, mismatches);
        $display("included size clamps, zero pivots, saturation and long output stalls");
        if (errors == 0 && pending_solutions.size() == 0)
            $display("tridiagonal_solver test passed");
        else
            $display("tridiagonal_solver test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tridiagonal_solver test failed");
        $finish;
    end

endmodule

`default_nettype wire
